>>> rtl/core/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types, constants and the divider step for the point projection.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int CoordW   = 32;             // Q16.16 coordinate
  localparam int ProdW    = 48;             // floored coef*coord product
  localparam int ClipW    = 50;             // clip value after the row sum
  localparam int QuotW    = 34;             // quotient bits below the limit
  localparam int NdcW     = 51;             // normalized value before mapping
  localparam int StepsPerStage = 2;         // quotient bits per divider stage
  localparam int DivStages = QuotW / StepsPerStage;
  localparam int DivLat   = DivStages + 1;  // plus the limit-check stage
  localparam int NumRegs  = 8;
  localparam int RegW     = 64;
  localparam int AddrW    = 6;

  localparam logic signed [ClipW-1:0] WMinRaw = ClipW'(6);
  localparam logic [NdcW:0]           QOne    = (NdcW+1)'(65536);

  typedef logic [RegW-1:0] reg_t;
  typedef reg_t [NumRegs-1:0] regs_t;

  localparam regs_t RegReset = {
    64'h0001_0000_0000_0000, 64'h0,
    64'h0000_0000_0001_0000, 64'h0,
    64'h0,                   64'h0001_0000_0000_0000,
    64'h0,                   64'h0000_0000_0001_0000
  };

  // clip values of one item on their way out of the transform
  typedef struct packed {
    logic                        valid;
    logic                        persp;
    logic [3:0][ClipW-1:0]       l;
  } xf_t;

  // item data traveling beside the divider lanes
  typedef struct packed {
    logic                        persp;
    logic                        wbad;
    logic [2:0]                  neg;
    logic [2:0][ClipW-1:0]       l;
  } side_t;

  typedef struct packed {
    logic             qb;
    logic [ClipW-1:0] r;
  } dstep_t;

  // one restoring division step: shift in a dividend bit, subtract if it fits
  function automatic dstep_t div_step(logic [ClipW-1:0] r, logic b, logic [ClipW-1:0] d);
    logic [ClipW:0] t;
    dstep_t         o;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      o.qb = 1'b1;
      o.r  = ClipW'(t - {1'b0, d});
    end else begin
      o.qb = 1'b0;
      o.r  = t[ClipW-1:0];
    end
    return o;
  endfunction

endpackage

>>> rtl/core/scp_regs.sv
// ----------------------------------------------------------------------------
// scp_regs
// Register file for the 4x4 matrix, written and read over the config port.
// ----------------------------------------------------------------------------
module scp_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scp_pkg::AddrW-1:0]   paddr,
  input  logic [scp_pkg::RegW-1:0]    pwdata,
  output logic [scp_pkg::RegW-1:0]    prdata,
  output logic                        pready,
  output scp_pkg::regs_t              regs_o
);
  import scp_pkg::*;

  regs_t regs_q;
  logic  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // write one register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= RegReset;
    end else if (wr_en) begin
      regs_q[paddr[AddrW-1:3]] <= pwdata;
    end
  end

  assign prdata = regs_q[paddr[AddrW-1:3]];
  assign regs_o = regs_q;

endmodule

>>> rtl/core/scp_xform.sv
// ----------------------------------------------------------------------------
// scp_xform
// Matrix transform: twelve products in one stage, row sums in the next.
// ----------------------------------------------------------------------------
module scp_xform (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 valid_i,
  input  logic                                 persp_i,
  input  logic [2:0][scp_pkg::CoordW-1:0]      p_i,
  input  scp_pkg::regs_t                       regs_i,
  output scp_pkg::xf_t                         xf_o
);
  import scp_pkg::*;

  logic [ProdW-1:0]   prod_q [4][3];
  logic [ProdW-1:0]   prod_d [4][3];
  logic               va_q, vb_q, pa_q, pb_q;
  logic [ClipW-1:0]   l_q [4];
  logic [ClipW-1:0]   l_d [4];
  logic [CoordW-1:0]  cf   [4][4];
  logic [2*CoordW-1:0] full;

  // unpack coefficients: row r, columns 0..3 from two registers
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      cf[r][0] = regs_i[2*r][CoordW-1:0];
      cf[r][1] = regs_i[2*r][RegW-1:CoordW];
      cf[r][2] = regs_i[2*r+1][CoordW-1:0];
      cf[r][3] = regs_i[2*r+1][RegW-1:CoordW];
    end
  end

  // multiply and floor each product to Q32.16
  always_comb begin
    full = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        full = $signed(cf[r][c]) * $signed(p_i[c]);
        prod_d[r][c] = full[2*CoordW-1:16];
      end
    end
  end

  // add the three products and the constant column
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      l_d[r] = ClipW'($signed(cf[r][3])) + ClipW'($signed(prod_q[r][0]))
             + ClipW'($signed(prod_q[r][1])) + ClipW'($signed(prod_q[r][2]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
      l_q    <= l_d;
      pa_q   <= persp_i;
      pb_q   <= pa_q;
    end
  end

  always_comb begin
    xf_o.valid = vb_q;
    xf_o.persp = pb_q;
    for (int r = 0; r < 4; r++) xf_o.l[r] = l_q[r];
  end

endmodule

>>> rtl/core/scp_div.sv
// ----------------------------------------------------------------------------
// scp_div
// Pipelined restoring divider: (n << 16) / d, two quotient bits per stage,
// with a flag for quotients at or above 2^34.
// ----------------------------------------------------------------------------
module scp_div (
  input  logic                        clk_i,
  input  logic                        adv_i,
  input  logic [scp_pkg::ClipW-1:0]   n_i,
  input  logic [scp_pkg::ClipW-1:0]   d_i,
  output logic [scp_pkg::QuotW-1:0]   q_o,
  output logic                        ovf_o
);
  import scp_pkg::*;

  logic [ClipW-1:0] r_q    [DivLat];
  logic [QuotW-1:0] bits_q [DivLat];
  logic [QuotW-1:0] q_q    [DivLat];
  logic [ClipW-1:0] d_q    [DivLat];
  logic             ovf_q  [DivLat];
  logic [ClipW-1:0] r_d    [DivLat];
  logic [QuotW-1:0] bits_d [DivLat];
  logic [QuotW-1:0] q_d    [DivLat];
  logic [ClipW-1:0] hi;
  dstep_t           st;

  assign hi = {18'b0, n_i[ClipW-1:18]};

  // load stage 0 from the inputs; run the steps of every later stage from the previous stage's registers
  always_comb begin
    st = '0;
    r_d[0]    = hi;
    bits_d[0] = {n_i[17:0], 16'b0};
    q_d[0]    = '0;
    for (int k = 1; k < DivLat; k++) begin
      r_d[k]    = r_q[k-1];
      bits_d[k] = bits_q[k-1];
      q_d[k]    = q_q[k-1];
      for (int s = 0; s < StepsPerStage; s++) begin
        st        = div_step(r_d[k], bits_d[k][QuotW-1], d_q[k-1]);
        r_d[k]    = st.r;
        bits_d[k] = {bits_d[k][QuotW-2:0], 1'b0};
        q_d[k]    = {q_d[k][QuotW-2:0], st.qb};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d_q[0]   <= d_i;
      ovf_q[0] <= hi >= d_i;
      for (int k = 0; k < DivLat; k++) begin
        r_q[k]    <= r_d[k];
        bits_q[k] <= bits_d[k];
        q_q[k]    <= q_d[k];
      end
      for (int k = 1; k < DivLat; k++) begin
        d_q[k]   <= d_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign q_o   = q_q[DivLat-1];
  assign ovf_o = ovf_q[DivLat-1];

endmodule

>>> rtl/core/shadow_coord_projection.sv
// ----------------------------------------------------------------------------
// shadow_coord_projection
// Projects a world point through a 4x4 matrix to texture coordinates.
// ----------------------------------------------------------------------------
// Usage: points enter on the s_axis channel (x, y, z in tdata, perspective
// flag in tuser) and leave on m_axis (u, v, depth in tdata, ok in tuser).
// The matrix is written over the APB-style port, two coefficients per 64-bit
// register; the user must write it only while no item is in flight (not enforced).
// The path holds 22 register stages: one input register, two transform
// stages (products, row sums), 18 divider stages (a limit check, then 17
// stages that retire two quotient bits each) and the output register.
// Throughput is one item per clock unless the output stalls; every stage advances together.
// Reset clears all valid bits and loads the identity matrix.
// When the receiver holds m_axis_tready low with an item waiting, the whole
// pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module shadow_coord_projection (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [95:0]                 s_axis_tdata,  // world_x, world_y, world_z
  input  logic                        s_axis_tuser,  // perspective
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [95:0]                 m_axis_tdata,  // tex_u, tex_v, depth
  output logic                        m_axis_tuser,  // ok
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scp_pkg::AddrW-1:0]   paddr,
  input  logic [scp_pkg::RegW-1:0]    pwdata,
  output logic [scp_pkg::RegW-1:0]    prdata,
  output logic                        pready
);
  import scp_pkg::*;

  regs_t                  regs;
  logic                   adv;
  logic                   in_v_q, in_p_q;
  logic [2:0][CoordW-1:0] in_d_q;
  xf_t                    xf;
  side_t                  side_d;
  side_t                  side_q [DivLat];
  logic [DivLat-1:0]      sv_q;
  logic [ClipW-1:0]       n   [3];
  logic [QuotW-1:0]       q   [3];
  logic [2:0]             ovf;
  logic [NdcW-1:0]        ndc [3];
  logic [NdcW:0]          sum [3];
  logic [NdcW-1:0]        res [3];
  logic                   ok_d;
  logic                   out_v_q, out_ok_q;
  logic [95:0]            out_d_q;
  side_t                  sl;

  // advance every stage unless a finished item is waiting
  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;

  scp_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .regs_o (regs)
  );

  // capture the input item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (adv) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_d_q <= s_axis_tdata;
      in_p_q <= s_axis_tuser;
    end
  end

  scp_xform u_xform (
    .clk_i, .rst_ni,
    .adv_i   (adv),
    .valid_i (in_v_q),
    .persp_i (in_p_q),
    .p_i     (in_d_q),
    .regs_i  (regs),
    .xf_o    (xf)
  );

  // split clip values into sign and magnitude, check w
  always_comb begin
    side_d.persp = xf.persp;
    side_d.wbad  = xf.persp && ($signed(xf.l[3]) <= $signed(WMinRaw));
    for (int i = 0; i < 3; i++) begin
      side_d.neg[i] = xf.l[i][ClipW-1];
      side_d.l[i]   = xf.l[i];
      n[i]          = xf.l[i][ClipW-1] ? ClipW'(-xf.l[i]) : xf.l[i];
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    scp_div u_div (
      .clk_i,
      .adv_i (adv),
      .n_i   (n[g]),
      .d_i   (xf.l[3]),
      .q_o   (q[g]),
      .ovf_o (ovf[g])
    );
  end

  // carry item data beside the divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else if (adv) begin
      sv_q <= {sv_q[DivLat-2:0], xf.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      for (int k = 1; k < DivLat; k++) side_q[k] <= side_q[k-1];
    end
  end

  // pick quotient or clip value, map to texture space, check range
  always_comb begin
    sl   = side_q[DivLat-1];
    ok_d = !sl.wbad;
    for (int i = 0; i < 3; i++) begin
      if (sl.persp) begin
        ndc[i] = sl.neg[i] ? NdcW'(-{17'b0, q[i]}) : {17'b0, q[i]};
        if (ovf[i]) ok_d = 1'b0;
      end else begin
        ndc[i] = {sl.l[i][ClipW-1], sl.l[i]};
      end
      if (i == 1) sum[i] = QOne - {ndc[i][NdcW-1], ndc[i]};
      else        sum[i] = {ndc[i][NdcW-1], ndc[i]} + QOne;
      res[i] = sum[i][NdcW:1];
      if (res[i][NdcW-1:CoordW-1] != '0 && res[i][NdcW-1:CoordW-1] != '1) ok_d = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= sv_q[DivLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_ok_q <= ok_d;
      out_d_q  <= ok_d ? {res[2][CoordW-1:0], res[1][CoordW-1:0], res[0][CoordW-1:0]}
                       : '0;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tdata  = out_d_q;

  // rejected items carry zero coordinates
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("rejected item with nonzero coordinates");

  // a frozen pipeline keeps its valid bits
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(sv_q) && $stable(in_v_q))
    else $error("valid bits moved during a stall");

  // a small or negative w in perspective mode never yields a valid projection
  a_w_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q[DivLat-1] && side_q[DivLat-1].wbad |-> !ok_d)
    else $error("item with bad w accepted");

  // output valid follows the end of the divider pipe when advancing
  a_out_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && sv_q[DivLat-1] |=> m_axis_tvalid)
    else $error("item lost at the output register");

endmodule
